@@ src/okl_pkg.sv @@
// Package for the ordered keyed list manager: field widths, action and
// status codes, sequencer state type and parameter defaults.
// No dependencies; every other file of the block imports it.
package okl_pkg;

   // Default sizes for the top-level parameters.
   localparam int ENTRIES_DEFAULT   = 16;
   localparam int PLAY_BITS_DEFAULT = 16;

   // Fixed widths of the item fields.
   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 4;
   localparam int PLAYS_W  = 16;
   localparam int SIZE_W   = 5;

   // Action codes carried by a request item.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_PLAY   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LIST   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   // Status codes carried by a response item.
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT_UP,
      S_PLACE,
      S_SHIFT_DN,
      S_LIST,
      S_REPLY
   } okl_state_type;

endpackage

@@ src/okl_if.sv @@
// Valid/ready channel interfaces for the request and response items.
// Depends on okl_pkg for the field widths.
interface okl_req_if
   import okl_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [POS_W-1:0]           position;
   logic signed [KEY_W-1:0]    key;

   modport source (output valid, output action, output position, output key,
                   input ready);
   modport sink   (input valid, input action, input position, input key,
                   output ready);
endinterface

interface okl_rsp_if
   import okl_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic [INDEX_W-1:0]         entry_index;
   logic signed [KEY_W-1:0]    entry_key;
   logic [PLAYS_W-1:0]         entry_plays;
   logic [SIZE_W-1:0]          list_size;
   logic                       last;

   modport source (output valid, output status, output entry_index,
                   output entry_key, output entry_plays, output list_size,
                   output last, input ready);
   modport sink   (input valid, input status, input entry_index,
                   input entry_key, input entry_plays, input list_size,
                   input last, output ready);
endinterface

@@ src/okl_store.sv @@
// Entry storage: one write port and one registered read port holding the
// key and play counter of every list slot. Depends on okl_pkg.
module okl_store
   import okl_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int PLAY_BITS = PLAY_BITS_DEFAULT,
   localparam int IW       = $clog2(ENTRIES)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IW-1:0]        wr_addr,
   input  logic [KEY_W-1:0]     wr_key,
   input  logic [PLAY_BITS-1:0] wr_plays,
   input  logic [IW-1:0]        rd_addr,
   output logic [KEY_W-1:0]     rd_key,
   output logic [PLAY_BITS-1:0] rd_plays
);

   logic [KEY_W-1:0]     key_mem_ff  [ENTRIES];
   logic [PLAY_BITS-1:0] play_mem_ff [ENTRIES];
   logic [KEY_W-1:0]     rd_key_ff;
   logic [PLAY_BITS-1:0] rd_plays_ff;

   // Read returns the old contents when the same slot is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr]  <= wr_key;
         play_mem_ff[wr_addr] <= wr_plays;
      end
      rd_key_ff   <= key_mem_ff[rd_addr];
      rd_plays_ff <= play_mem_ff[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_plays = rd_plays_ff;

endmodule

@@ src/ordered_keyed_list_manager.sv @@
// Ordered keyed list manager, top level: action sequencer, shared key
// comparator and response register. Depends on okl_pkg, okl_if, okl_store.
//
// The block keeps an ordered list of up to ENTRIES entries, each a unique
// 32-bit key with a saturating play counter, in a single-port-read memory.
// A request item carries one action (insert, remove, find, play, list all
// or clear) and the block is busy until that action is finished; while a
// response item waits to be taken, the next request can already be
// accepted. All work runs through one memory read port and one key
// comparator, one slot per cycle while the response register is free.
// Find, play and remove search from the head until the key is found or
// the list ends; for remove, moving later entries down takes the place
// of the rest of the search. Insert searches the whole list unless it
// finds the key, then moves the entries from the insert point on up by
// one; list all reads one entry after another; clear or an unused action
// code goes straight to the reply.
// Every action produces exactly one response item, except list all on a
// non-empty list, which produces one per entry, head first, with last set
// on the final one. The response reports the list size after the action.
module ordered_keyed_list_manager
   import okl_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int PLAY_BITS = PLAY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   okl_req_if.sink    req_ch,
   okl_rsp_if.source  rsp_ch
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

   // Sequencer state and the latched request.
   okl_state_type        state_ff, state_in;
   logic [ACTION_W-1:0]  act_ff, act_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic [IW-1:0]        look_ff, look_in;
   logic                 pend_ff, pend_in;

   // The entry that the pending reply reports.
   logic [STATUS_W-1:0]  st_ff, st_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic [KEY_W-1:0]     hit_key_ff, hit_key_in;
   logic [PLAY_BITS-1:0] hit_plays_ff, hit_plays_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [PLAYS_W-1:0]   rsp_plays_ff;
   logic [SIZE_W-1:0]    rsp_size_ff;
   logic                 rsp_last_ff;

   // Memory port.
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [KEY_W-1:0]     wr_key;
   logic [PLAY_BITS-1:0] wr_plays;
   logic [IW-1:0]        rd_addr;
   logic [KEY_W-1:0]     rd_key;
   logic [PLAY_BITS-1:0] rd_plays;

   // Response load from the sequencer.
   logic                 load;
   logic                 out_free;
   logic [STATUS_W-1:0]  ld_status;
   logic [31:0]          ld_index;
   logic [KEY_W-1:0]     ld_key;
   logic [PLAY_BITS-1:0] ld_plays;
   logic [31:0]          ld_plays_x;
   logic                 ld_last;

   // Index arithmetic is done on zero-extended copies.
   logic [31:0] cnt_x, scan_x, look_x, pos_x, hidx_x, ins_x, size_x;
   logic        key_match;
   logic [PLAY_BITS-1:0] play_next;

   assign cnt_x  = 32'(count_ff);
   assign scan_x = 32'(scan_ff);
   assign look_x = 32'(look_ff);
   assign pos_x  = 32'(pos_ff);
   assign hidx_x = 32'(hit_idx_ff);
   assign ins_x  = (pos_x < cnt_x) ? pos_x : cnt_x;

   // The shared comparator: the slot read in the previous cycle against
   // the requested key.
   assign key_match = pend_ff && (rd_key == key_ff);
   assign play_next = (&rd_plays) ? rd_plays : rd_plays + 1'b1;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   okl_store #(
      .ENTRIES   (ENTRIES),
      .PLAY_BITS (PLAY_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_plays (wr_plays),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_plays (rd_plays)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      scan_ff      <= scan_in;
      look_ff      <= look_in;
      st_ff        <= st_in;
      hit_idx_ff   <= hit_idx_in;
      hit_key_ff   <= hit_key_in;
      hit_plays_ff <= hit_plays_in;
      if (load) begin
         rsp_status_ff <= ld_status;
         rsp_index_ff  <= ld_index[INDEX_W-1:0];
         rsp_key_ff    <= ld_key;
         rsp_plays_ff  <= (ld_plays_x > 32'h0000_FFFF) ? 16'hFFFF
                                                       : ld_plays_x[PLAYS_W-1:0];
         rsp_size_ff   <= size_x[SIZE_W-1:0];
         rsp_last_ff   <= ld_last;
      end
   end

   assign ld_plays_x   = 32'(ld_plays);
   assign size_x       = 32'(count_ff);
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && !rsp_ch.ready);

   // Sequencer: next state, memory port and response load.
   always_comb begin
      logic [31:0] tmp;
      state_in     = state_ff;
      act_in       = act_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      look_in      = look_ff;
      pend_in      = 1'b0;
      st_in        = st_ff;
      hit_idx_in   = hit_idx_ff;
      hit_key_in   = hit_key_ff;
      hit_plays_in = hit_plays_ff;
      rd_addr      = scan_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_key       = key_ff;
      wr_plays     = '0;
      load         = 1'b0;
      ld_status    = st_ff;
      ld_index     = hidx_x;
      ld_key       = hit_key_ff;
      ld_plays     = hit_plays_ff;
      ld_last      = 1'b1;
      tmp          = '0;
      req_ch.ready = (state_ff == S_IDLE);

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               act_in       = req_ch.action;
               pos_in       = req_ch.position;
               key_in       = req_ch.key;
               scan_in      = '0;
               st_in        = ST_OK;
               hit_idx_in   = '0;
               hit_key_in   = '0;
               hit_plays_in = '0;
               rd_addr      = '0;
               if (req_ch.action == ACT_INSERT) begin
                  state_in = S_SEARCH;
               end else if (req_ch.action == ACT_REMOVE || req_ch.action == ACT_FIND ||
                            req_ch.action == ACT_PLAY) begin
                  if (count_ff == '0) begin
                     st_in    = ST_EMPTY;
                     state_in = S_REPLY;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end else if (req_ch.action == ACT_LIST) begin
                  if (count_ff == '0) begin
                     st_in    = ST_EMPTY;
                     state_in = S_REPLY;
                  end else begin
                     state_in = S_LIST;
                  end
               end else if (req_ch.action == ACT_CLEAR) begin
                  count_in = '0;
                  state_in = S_REPLY;
               end else begin
                  state_in = S_REPLY;
               end
            end
         end

         // Walk from the head: issue a read each cycle, compare the slot
         // read in the cycle before.
         S_SEARCH: begin
            if (key_match) begin
               hit_idx_in   = look_ff;
               hit_key_in   = rd_key;
               hit_plays_in = rd_plays;
               st_in        = ST_OK;
               state_in     = S_REPLY;
               if (act_ff == ACT_INSERT) begin
                  st_in = ST_DUPLICATE;
               end else if (act_ff == ACT_PLAY) begin
                  hit_plays_in = play_next;
                  wr_en        = 1'b1;
                  wr_addr      = look_ff;
                  wr_key       = rd_key;
                  wr_plays     = play_next;
               end else if (act_ff == ACT_REMOVE) begin
                  tmp = look_x + 32'd1;
                  if (tmp < cnt_x) begin
                     rd_addr  = tmp[IW-1:0];
                     scan_in  = look_x[CW-1:0];
                     state_in = S_SHIFT_DN;
                  end else begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end else if (scan_x < cnt_x) begin
               rd_addr = scan_ff[IW-1:0];
               look_in = scan_ff[IW-1:0];
               pend_in = 1'b1;
               scan_in = scan_ff + 1'b1;
            end else if (act_ff == ACT_INSERT) begin
               if (count_ff == FULL_COUNT) begin
                  st_in    = ST_FULL;
                  state_in = S_REPLY;
               end else begin
                  hit_idx_in   = ins_x[IW-1:0];
                  hit_key_in   = key_ff;
                  hit_plays_in = '0;
                  st_in        = ST_OK;
                  if (ins_x == cnt_x) begin
                     state_in = S_PLACE;
                  end else begin
                     tmp      = cnt_x - 32'd1;
                     rd_addr  = tmp[IW-1:0];
                     scan_in  = count_ff;
                     state_in = S_SHIFT_UP;
                  end
               end
            end else begin
               st_in    = ST_NOT_FOUND;
               state_in = S_REPLY;
            end
         end

         // Move entries one place toward the tail, from the tail down to
         // the insert point; scan_ff is the slot being written.
         S_SHIFT_UP: begin
            wr_en    = 1'b1;
            wr_addr  = scan_ff[IW-1:0];
            wr_key   = rd_key;
            wr_plays = rd_plays;
            tmp      = scan_x - 32'd1;
            if (tmp == hidx_x) begin
               state_in = S_PLACE;
            end else begin
               tmp     = scan_x - 32'd2;
               rd_addr = tmp[IW-1:0];
               scan_in = scan_ff - 1'b1;
            end
         end

         S_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = hit_idx_ff;
            wr_key   = key_ff;
            wr_plays = '0;
            count_in = count_ff + 1'b1;
            state_in = S_REPLY;
         end

         // Move entries one place toward the head over the removed slot.
         S_SHIFT_DN: begin
            wr_en    = 1'b1;
            wr_addr  = scan_ff[IW-1:0];
            wr_key   = rd_key;
            wr_plays = rd_plays;
            tmp      = scan_x + 32'd2;
            if (tmp < cnt_x) begin
               rd_addr = tmp[IW-1:0];
               scan_in = scan_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_REPLY;
            end
         end

         // One response per entry; the next slot is read as the current
         // one is handed to the response register.
         S_LIST: begin
            ld_status = ST_OK;
            ld_index  = scan_x;
            ld_key    = rd_key;
            ld_plays  = rd_plays;
            tmp       = scan_x + 32'd1;
            ld_last   = (tmp == cnt_x);
            if (out_free) begin
               load = 1'b1;
               if (tmp == cnt_x) begin
                  state_in = S_IDLE;
               end else begin
                  rd_addr = tmp[IW-1:0];
                  scan_in = scan_ff + 1'b1;
               end
            end
         end

         S_REPLY: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_index = rsp_index_ff;
   assign rsp_ch.entry_key   = rsp_key_ff;
   assign rsp_ch.entry_plays = rsp_plays_ff;
   assign rsp_ch.list_size   = rsp_size_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // The list never holds more entries than there are slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("list size beyond capacity");

   // Once a request is taken, the block is busy on the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("request taken while busy");

   // A slot under comparison always lies inside the occupied part.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH && pend_ff) |-> (look_x < cnt_x))
      else $error("search compared an unoccupied slot");

   // Placing a new entry grows the list by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLACE) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow the list by one");

   // The final list response returns the sequencer to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST && load && ld_last) |=> (state_ff == S_IDLE))
      else $error("list walk did not end after its last entry");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the ordered keyed list manager: directed and
// random list actions, each reply checked against an in-bench list predictor.
// Depends on okl_pkg, okl_if and the ordered_keyed_list_manager RTL.
module tb_top;
   import okl_pkg::*;

   localparam int ENTRIES      = 16;
   localparam int PLAY_BITS    = 16;
   // The limit leaves a wide margin over a correct run, even one with every
   // list walk held up by the longest receiver stalls.
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 200;
   // Longest single action (insert into a nearly full list) plus some slack.
   localparam int SETTLE_CYCLES = 2 * ENTRIES + 8;
   localparam int POOL_SIZE    = 24;
   localparam int PLAY_ROUNDS  = 8;
   localparam logic [PLAY_BITS-1:0] PLAY_MAX = '1;

   // Action codes that the block does not define; they must leave the list
   // alone and still produce a single reply.
   localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

   // One reply item as the predictor expects it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  entry_index;
      logic [KEY_W-1:0]    entry_key;
      logic [PLAYS_W-1:0]  entry_plays;
      logic [SIZE_W-1:0]   list_size;
      logic                last;
   } reply_type;

   // Random traffic runs in episodes: growing the list until it is full,
   // a general mix, or shrinking it again.
   typedef enum {EP_FILL, EP_MIXED, EP_DRAIN} episode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   okl_req_if req_ch ();
   okl_rsp_if rsp_ch ();

   ordered_keyed_list_manager #(
      .ENTRIES   (ENTRIES),
      .PLAY_BITS (PLAY_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // Shadow copy of the list as the block should hold it.
   logic [KEY_W-1:0]     shadow_keys  [ENTRIES];
   logic [PLAY_BITS-1:0] shadow_plays [ENTRIES];
   int                   shadow_count = 0;

   // Replies predicted for accepted items, oldest first.
   reply_type            expected_replies [$];

   logic [KEY_W-1:0]     key_pool [POOL_SIZE];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;

   // Sender and receiver pacing.
   bit                   sender_gaps_on = 1'b1;
   bit                   rsp_full_speed = 1'b0;
   int                   burst_left = 0;
   logic [31:0]          stall_bits = '1;
   int                   stall_phase = 0;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Searches the shadow list from the head; -1 means the key is absent.
   function automatic int locate_key(logic [KEY_W-1:0] key);
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_keys[i] == key) return i;
      end
      return -1;
   endfunction

   // Queues one expected reply. The size field always reflects the list
   // after the action, so callers update the shadow count first.
   function automatic void push_reply(logic [STATUS_W-1:0] status, int idx,
                                      logic [KEY_W-1:0] key,
                                      logic [PLAY_BITS-1:0] plays, bit last);
      reply_type r;
      r.status      = status;
      r.entry_index = idx[INDEX_W-1:0];
      r.entry_key   = key;
      r.entry_plays = (plays > {PLAYS_W{1'b1}}) ? '1 : PLAYS_W'(plays);
      r.list_size   = shadow_count[SIZE_W-1:0];
      r.last        = last;
      expected_replies.push_back(r);
   endfunction

   // Applies one action to the shadow list and queues the replies it causes.
   function automatic void apply_list_action(logic [ACTION_W-1:0] action,
                                             logic [POS_W-1:0] position,
                                             logic [KEY_W-1:0] key);
      int                   hit;
      int                   slot;
      logic [KEY_W-1:0]     hit_key;
      logic [PLAY_BITS-1:0] hit_plays;
      hit = locate_key(key);
      case (action)
         ACT_INSERT: begin
            if (hit >= 0) begin
               // A duplicate reports the entry that already holds the key.
               push_reply(ST_DUPLICATE, hit, shadow_keys[hit], shadow_plays[hit], 1'b1);
            end else if (shadow_count >= ENTRIES) begin
               push_reply(ST_FULL, 0, '0, '0, 1'b1);
            end else begin
               // Positions at or past the size append at the tail.
               slot = (int'(position) < shadow_count) ? int'(position) : shadow_count;
               for (int i = shadow_count; i > slot; i--) begin
                  shadow_keys[i]  = shadow_keys[i-1];
                  shadow_plays[i] = shadow_plays[i-1];
               end
               shadow_keys[slot]  = key;
               shadow_plays[slot] = '0;
               shadow_count++;
               push_reply(ST_OK, slot, key, '0, 1'b1);
            end
         end
         ACT_REMOVE, ACT_FIND, ACT_PLAY: begin
            if (shadow_count == 0) begin
               push_reply(ST_EMPTY, 0, '0, '0, 1'b1);
            end else if (hit < 0) begin
               push_reply(ST_NOT_FOUND, 0, '0, '0, 1'b1);
            end else begin
               hit_key   = shadow_keys[hit];
               hit_plays = shadow_plays[hit];
               if (action == ACT_REMOVE) begin
                  for (int i = hit; i + 1 < shadow_count; i++) begin
                     shadow_keys[i]  = shadow_keys[i+1];
                     shadow_plays[i] = shadow_plays[i+1];
                  end
                  shadow_count--;
               end else if (action == ACT_PLAY) begin
                  // The counter sticks at its maximum.
                  if (hit_plays != PLAY_MAX) hit_plays++;
                  shadow_plays[hit] = hit_plays;
               end
               push_reply(ST_OK, hit, hit_key, hit_plays, 1'b1);
            end
         end
         ACT_LIST: begin
            if (shadow_count == 0) begin
               push_reply(ST_EMPTY, 0, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < shadow_count; i++) begin
                  push_reply(ST_OK, i, shadow_keys[i], shadow_plays[i],
                             i == shadow_count - 1);
               end
            end
         end
         ACT_CLEAR: begin
            shadow_count = 0;
            push_reply(ST_OK, 0, '0, '0, 1'b1);
         end
         default: begin
            push_reply(ST_OK, 0, '0, '0, 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Drives one item and holds it until the block takes it. With sender
   // gaps on it works in bursts; between bursts valid drops for a random gap.
   task automatic send_item(logic [ACTION_W-1:0] action, logic [POS_W-1:0] position,
                            logic [KEY_W-1:0] key);
      int gap;
      if (sender_gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.action   <= action;
      req_ch.position <= position;
      req_ch.key      <= key;
      // The block takes items strictly in order, so predicting now is the
      // same as predicting at the accepting edge.
      apply_list_action(action, position, key);
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops sending and waits until every predicted reply has arrived. It
   // never returns without waiting on a clock edge, so the next item starts
   // on a fresh edge.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Reply side
   // ---------------------------------------------------------------------

   // The receiver stalls on a pattern picked anew each time stall_phase wraps: always
   // ready, random, sparse, or a long stall after a ready stretch.
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_bits = '1;
            1:       stall_bits = $urandom;
            2:       stall_bits = $urandom & $urandom;
            default: stall_bits = {16'h0000, 16'hFFFF};
         endcase
      end
      rsp_ch.ready <= rsp_full_speed | stall_bits[stall_phase];
      stall_phase = (stall_phase + 1) % 32;
   end

   // Reports one field that does not match; returns 1 on a mismatch.
   function automatic bit field_differs(string name, logic [KEY_W-1:0] expected,
                                        logic [KEY_W-1:0] actual);
      if (expected !== actual) begin
         if (mismatch_count < MAX_REPORTS) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, expected, actual);
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Every reply taken is compared with the oldest expectation.
   always @(posedge clock) begin : reply_checker
      reply_type want;
      bit        bad;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_replies.size() == 0) begin
            if (mismatch_count < MAX_REPORTS) begin
               $error("reply with no item outstanding: status %0d key 'h%0h",
                      rsp_ch.status, rsp_ch.entry_key);
            end
            mismatch_count++;
         end else begin
            want = expected_replies.pop_front();
            bad  = 1'b0;
            bad |= field_differs("status", want.status, rsp_ch.status);
            bad |= field_differs("entry_index", want.entry_index, rsp_ch.entry_index);
            bad |= field_differs("entry_key", want.entry_key, rsp_ch.entry_key);
            bad |= field_differs("entry_plays", want.entry_plays, rsp_ch.entry_plays);
            bad |= field_differs("list_size", want.list_size, rsp_ch.list_size);
            bad |= field_differs("last", want.last, rsp_ch.last);
            if (bad) mismatch_count++;
         end
      end
   end

   // A hung block must not hang the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every lookup on an empty list reports empty; clear and the undefined
   // action codes still give one reply each.
   task automatic test_empty_list();
      send_item(ACT_REMOVE, 5'd0, 32'h8000_0000);
      send_item(ACT_FIND, 5'd31, 32'h7FFF_FFFF);
      send_item(ACT_PLAY, 5'd0, 32'h0000_0000);
      send_item(ACT_LIST, 5'd16, 32'hFFFF_FFFF);
      send_item(ACT_CLEAR, 5'd31, 32'hFFFF_FFFF);
      send_item(ACT_SPARE_A, 5'd31, 32'hFFFF_FFFF);
      send_item(ACT_SPARE_B, 5'd0, 32'h0000_0000);
   endtask

   // Inserts at the head, the middle and past the tail with the extreme
   // keys, then a duplicate, lookups that hit and miss, and plays.
   task automatic test_insert_and_lookup();
      send_item(ACT_INSERT, 5'd31, 32'h7FFF_FFFF);
      send_item(ACT_INSERT, 5'd0, 32'h8000_0000);
      send_item(ACT_INSERT, 5'd1, 32'h0000_0000);
      send_item(ACT_INSERT, 5'd16, 32'hFFFF_FFFF);
      send_item(ACT_INSERT, 5'd0, 32'h0000_0000);
      send_item(ACT_FIND, 5'd31, 32'hFFFF_FFFF);
      send_item(ACT_FIND, 5'd0, 32'h1234_5678);
      send_item(ACT_PLAY, 5'd0, 32'h8000_0000);
      send_item(ACT_PLAY, 5'd0, 32'h8000_0000);
      send_item(ACT_PLAY, 5'd0, 32'h0000_0000);
      send_item(ACT_SPARE_A, 5'd3, 32'h7FFF_FFFF);
      send_item(ACT_LIST, 5'd0, 32'h0000_0000);
   endtask

   // Removal at both ends and of an absent key, then clear.
   task automatic test_remove_and_clear();
      send_item(ACT_REMOVE, 5'd0, 32'h8000_0000);
      send_item(ACT_REMOVE, 5'd0, 32'hFFFF_FFFF);
      send_item(ACT_REMOVE, 5'd0, 32'h0000_0001);
      send_item(ACT_LIST, 5'd0, 32'h0000_0000);
      send_item(ACT_CLEAR, 5'd0, 32'h0000_0000);
      send_item(ACT_LIST, 5'd0, 32'h0000_0000);
   endtask

   // Keys mostly come from the list or a small pool so that hits and
   // duplicates are common; the rest are fully random. fresh_bias favours random keys.
   function automatic logic [KEY_W-1:0] pick_key(bit fresh_bias);
      int roll;
      roll = $urandom_range(0, 99);
      if (fresh_bias && roll < 60) return $urandom;
      if (roll < 50 && shadow_count > 0) return shadow_keys[$urandom_range(0, shadow_count - 1)];
      if (roll < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(episode_type ep);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return ($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
      if (roll < 10) return ACT_LIST;
      case (ep)
         EP_FILL:  return (roll < 80) ? ACT_INSERT : ACT_PLAY;
         EP_DRAIN: return (roll < 70) ? ACT_REMOVE : ACT_FIND;
         default: begin
            // Clear only shows up in the mixed episodes so that a fill
            // episode always reaches a full list.
            if (roll < 13) return ACT_CLEAR;
            if (roll < 40) return ACT_INSERT;
            if (roll < 55) return ACT_REMOVE;
            if (roll < 75) return ACT_FIND;
            return ACT_PLAY;
         end
      endcase
   endfunction

   // Random traffic in episodes. The first episode always fills the list
   // and then keeps inserting for a few items, so the full case is hit.
   task automatic test_random_traffic(int n_items);
      episode_type          ep;
      int                   sent;
      int                   done;
      int                   span;
      int                   extra;
      logic [ACTION_W-1:0]  action;
      logic [POS_W-1:0]     position;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      ep   = EP_FILL;
      sent = 0;
      while (sent < n_items) begin
         // Some episodes run back to back without any sender gaps.
         sender_gaps_on = ($urandom_range(0, 3) != 0);
         span  = $urandom_range(15, 35);
         extra = 4;
         done  = 0;
         while ((ep == EP_FILL) ? (extra > 0) : (done < span && sent + done < n_items)) begin
            action = pick_action(ep);
            if ($urandom_range(0, 1) != 0) begin
               position = POS_W'($urandom_range(0, 31));
            end else begin
               position = POS_W'($urandom_range(0, shadow_count));
            end
            send_item(action, position, pick_key(ep == EP_FILL && action == ACT_INSERT));
            done++;
            if (shadow_count == ENTRIES) extra--;
         end
         sent += done;
         // Now and then the sender holds off until the block has caught up.
         if ($urandom_range(0, 2) == 0) wait_drained();
         case ($urandom_range(0, 3))
            0:       ep = EP_FILL;
            1:       ep = EP_DRAIN;
            default: ep = EP_MIXED;
         endcase
      end
      sender_gaps_on = 1'b1;
   endtask

   // Plays one entry several times in a row. The entry sits behind another
   // one so every play has to walk the list. This runs with no idling on
   // either side, so plays follow each other as fast as the block allows.
   task automatic test_play_count();
      logic [KEY_W-1:0] played_key;
      played_key     = 32'hA5A5_0002;
      sender_gaps_on = 1'b0;
      rsp_full_speed = 1'b1;
      send_item(ACT_CLEAR, 5'd0, 32'h0000_0000);
      send_item(ACT_INSERT, 5'd0, played_key);
      send_item(ACT_INSERT, 5'd0, 32'h5A5A_0001);
      for (int n = 0; n < PLAY_ROUNDS; n++) begin
         send_item(ACT_PLAY, 5'd0, played_key);
      end
      send_item(ACT_LIST, 5'd0, 32'h0000_0000);
      send_item(ACT_REMOVE, 5'd0, played_key);
      wait_drained();
      sender_gaps_on = 1'b1;
      rsp_full_speed = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin : test_sequence
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_INSERT;
      req_ch.position = '0;
      req_ch.key      = '0;
      rsp_ch.ready    = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      wait_drained();
      test_insert_and_lookup();
      wait_drained();
      test_remove_and_clear();
      wait_drained();
      test_random_traffic(130);
      wait_drained();
      test_play_count();
      wait_drained();

      // Give the block time to show any reply that should not come.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
